// ===== hdl/wave_pattern_pixel_generator_assert.svh =====
// ----------------------------------------------------------------------------
// wave_pattern_pixel_generator_assert.svh
// assertion macros used by the plasma pattern generator rtl
// ----------------------------------------------------------------------------
`ifndef WAVE_PATTERN_PIXEL_GENERATOR_ASSERT_SVH
`define WAVE_PATTERN_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WPPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WPPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wppg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wppg_pkg
// types, register indexes, divider constants and the triangle wave for the
// plasma pattern generator
// ----------------------------------------------------------------------------
package wppg_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN_SEL        = 3'd0;
  localparam logic [2:0] REG_TIME_PHASE         = 3'd1;
  localparam logic [2:0] REG_SOURCE_PHASE_ONE   = 3'd2;
  localparam logic [2:0] REG_SOURCE_PHASE_TWO   = 3'd3;
  localparam logic [2:0] REG_SOURCE_PHASE_THREE = 3'd4;
  localparam logic [2:0] REG_FIELD_WIDTH        = 3'd5;
  localparam logic [2:0] REG_FIELD_HEIGHT       = 3'd6;

  // pattern modes
  localparam logic MODE_FOUR_WAVE = 1'b0;
  localparam logic MODE_SOURCES   = 1'b1;

  // reset values and minimums of the field size
  localparam logic [8:0] FIELD_WIDTH_RESET  = 9'd320;
  localparam logic [7:0] FIELD_HEIGHT_RESET = 8'd240;
  localparam logic [8:0] FIELD_WIDTH_MIN    = 9'd40;
  localparam logic [7:0] FIELD_HEIGHT_MIN   = 8'd30;

  // phase dividers: four time phase waves, then source two and source three rows
  localparam int          NUM_PHASE_DIV = 6;
  localparam logic [3:0]  PHASE_DIVISOR [NUM_PHASE_DIV] =
    '{4'd7, 4'd11, 4'd5, 4'd13, 4'd3, 4'd5};
  // rounded-up 2^16 / divisor, exact for a partial dividend below 4096
  localparam logic [14:0] PHASE_RECIP [NUM_PHASE_DIV] =
    '{15'd9363, 15'd5958, 15'd13108, 15'd5042, 15'd21846, 15'd13108};
  localparam int          PHASE_RECIP_SHIFT = 16;
  // the 32-bit phases are divided one byte per step
  localparam int          PHASE_DIGITS = 4;

  // source position scaling: three x positions, then three y positions
  localparam int          NUM_SCALE   = 6;
  localparam int          SCALE_BITS  = 17;
  // rounded-up 2^25 / 255, exact for a scaled position below 2^17
  localparam logic [17:0] SCALE_RECIP = 18'd131587;
  localparam int          SCALE_SHIFT = 25;

  // number of interference sources and their distance multipliers
  localparam int          NUM_SOURCES = 3;
  localparam logic [7:0]  SOURCE_MUL [NUM_SOURCES] = '{8'd8, 8'd6, 8'd5};

  // reciprocal of three for a sum below 1024
  localparam logic [9:0]  RECIP_THREE = 10'd683;
  localparam int          RECIP_SHIFT = 11;

  // sequencer that derives phases and source positions from the registers
  typedef enum logic [2:0] {
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_MUL,
    SEQ_SCALE,
    SEQ_READY
  } seq_state_t;

  // triangle wave of an 8-bit phase
  function automatic logic [7:0] tri_level(input logic [7:0] p);
    logic [7:0] twice;
    twice = {p[5:0], 1'b0};
    case (p[7:6])
      2'd0:    tri_level = 8'd128 + twice;
      2'd1:    tri_level = 8'd255 - twice;
      2'd2:    tri_level = 8'd127 - twice;
      default: tri_level = twice;
    endcase
  endfunction

endpackage

// ===== hdl/wave_pattern_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_pattern_pixel_generator
// plasma pattern: one 8-bit level per cell from four waves or three sources
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock and returns its level through a
// four-stage pipeline (phase arguments and distances, wave arguments,
// triangle sum, average). After reset and after every register write a
// sequencer re-derives the wave phases and source positions: a load step,
// byte-wide long division of the 32-bit phases by 7, 11, 5, 13, 3 and 5
// with a reciprocal multiply per digit, a multiply step and a step dividing
// the scaled positions by 255 with a reciprocal multiply. While it runs,
// pixel_stall is high and cfg_ready is low; otherwise the rate is one item
// per cycle, limited only by level_stall.
// ----------------------------------------------------------------------------
`include "wave_pattern_pixel_generator_assert.svh"

module wave_pattern_pixel_generator
  import wppg_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // pixel items in
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  // level items out
  output logic        level_valid,
  input  logic        level_stall,
  output logic [7:0]  level
);

  // configuration registers
  logic        pattern_sel;
  logic [31:0] time_phase;
  logic [31:0] source_phase [NUM_SOURCES];
  logic [8:0]  field_width;
  logic [7:0]  field_height;

  logic        cfg_write;
  logic        busy;

  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sel  <= MODE_FOUR_WAVE;
      time_phase   <= '0;
      for (int k = 0; k < NUM_SOURCES; k++) begin
        source_phase[k] <= '0;
      end
      field_width  <= FIELD_WIDTH_RESET;
      field_height <= FIELD_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_SEL:        pattern_sel     <= cfg_data[0];
        REG_TIME_PHASE:         time_phase      <= cfg_data;
        REG_SOURCE_PHASE_ONE:   source_phase[0] <= cfg_data;
        REG_SOURCE_PHASE_TWO:   source_phase[1] <= cfg_data;
        REG_SOURCE_PHASE_THREE: source_phase[2] <= cfg_data;
        REG_FIELD_WIDTH:        field_width     <= cfg_data[8:0];
        REG_FIELD_HEIGHT:       field_height    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // field size saturated into its legal range
  logic [8:0] clamp_width;
  logic [7:0] clamp_height;

  always_comb begin
    if (field_width < FIELD_WIDTH_MIN) begin
      clamp_width = FIELD_WIDTH_MIN;
    end else if (32'(field_width) > MAX_WIDTH) begin
      clamp_width = 9'(MAX_WIDTH);
    end else begin
      clamp_width = field_width;
    end
    if (field_height < FIELD_HEIGHT_MIN) begin
      clamp_height = FIELD_HEIGHT_MIN;
    end else if (32'(field_height) > MAX_HEIGHT) begin
      clamp_height = 8'(MAX_HEIGHT);
    end else begin
      clamp_height = field_height;
    end
  end

  // sequencer state
  seq_state_t state;
  seq_state_t state_next;
  logic [1:0] step;
  logic [1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_LOAD;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      SEQ_LOAD: begin
        state_next = SEQ_DIV;
        step_next  = '0;
      end
      SEQ_DIV: begin
        step_next = step + 2'd1;
        if (step == 2'(PHASE_DIGITS - 1)) begin
          state_next = SEQ_MUL;
        end
      end
      SEQ_MUL: begin
        state_next = SEQ_SCALE;
      end
      SEQ_SCALE: begin
        state_next = SEQ_READY;
      end
      SEQ_READY: begin
        if (cfg_write) begin
          state_next = SEQ_LOAD;
        end
      end
      default: state_next = SEQ_LOAD;
    endcase
  end

  assign busy      = (state != SEQ_READY);
  assign cfg_ready = (state == SEQ_READY);

  // phases by byte-wide long division, each digit by a reciprocal multiply
  logic [31:0] dvd_a   [NUM_PHASE_DIV];
  logic [3:0]  rem_a   [NUM_PHASE_DIV];
  logic [7:0]  quo_a   [NUM_PHASE_DIV];
  logic [11:0] part_a  [NUM_PHASE_DIV];
  logic [7:0]  digit_a [NUM_PHASE_DIV];

  always_comb begin
    for (int k = 0; k < NUM_PHASE_DIV; k++) begin
      part_a[k]  = {rem_a[k], dvd_a[k][31:24]};
      digit_a[k] = 8'((24'(part_a[k]) * 24'(PHASE_RECIP[k])) >> PHASE_RECIP_SHIFT);
    end
  end

  // the last digit is the low byte of the quotient
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PHASE_DIV; k++) begin
      if (state == SEQ_LOAD) begin
        if (k < 4) begin
          dvd_a[k] <= time_phase;
        end else if (k == 4) begin
          dvd_a[k] <= source_phase[1];
        end else begin
          dvd_a[k] <= source_phase[2];
        end
        rem_a[k] <= '0;
        quo_a[k] <= '0;
      end else if (state == SEQ_DIV) begin
        dvd_a[k] <= {dvd_a[k][23:0], 8'h00};
        rem_a[k] <= 4'(part_a[k] - 12'(digit_a[k]) * 12'(PHASE_DIVISOR[k]));
        quo_a[k] <= digit_a[k];
      end
    end
  end

  // source position scaling: size times triangle, then divided by 255
  logic [7:0]            tri_src [NUM_SCALE];
  logic [SCALE_BITS-1:0] dvd_b   [NUM_SCALE];
  logic [8:0]            quo_b   [NUM_SCALE];

  always_comb begin
    tri_src[0] = tri_level(source_phase[0][7:0]);
    tri_src[1] = tri_level(source_phase[1][7:0]);
    tri_src[2] = tri_level(source_phase[2][7:0]);
    tri_src[3] = tri_level(source_phase[0][8:1]);
    tri_src[4] = tri_level(quo_a[4]);
    tri_src[5] = tri_level(quo_a[5]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_SCALE; k++) begin
      if (state == SEQ_MUL) begin
        if (k < NUM_SOURCES) begin
          dvd_b[k] <= SCALE_BITS'(clamp_width) * SCALE_BITS'(tri_src[k]);
        end else begin
          dvd_b[k] <= SCALE_BITS'(clamp_height) * SCALE_BITS'(tri_src[k]);
        end
      end else if (state == SEQ_SCALE) begin
        quo_b[k] <= 9'((35'(dvd_b[k]) * 35'(SCALE_RECIP)) >> SCALE_SHIFT);
      end
    end
  end

  // pipeline flow control: a stage moves when it is empty or the next one moves
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || !level_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pixel_stall = busy || !en1;
  assign level_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pixel_valid && !busy;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: wave arguments for four-wave mode, distances to sources
  logic [7:0] x8;
  logic [7:0] xy;
  logic [7:0] arg_in [4];
  logic [8:0] dx_in  [NUM_SOURCES];
  logic [7:0] dy_in  [NUM_SOURCES];

  always_comb begin
    x8 = pixel_x[7:0];
    xy = x8 + pixel_y;
    arg_in[0] = {pixel_x[4:0], 3'b000} + quo_a[0];
    arg_in[1] = {pixel_y[4:0], 3'b000} - pixel_y + quo_a[1];
    arg_in[2] = {xy[5:0], 2'b00} + xy + quo_a[2];
    arg_in[3] = {x8[6:0], 1'b0} + x8 + {pixel_y[5:0], 2'b00} + pixel_y + quo_a[3];
    for (int k = 0; k < NUM_SOURCES; k++) begin
      if (pixel_x >= quo_b[k]) begin
        dx_in[k] = pixel_x - quo_b[k];
      end else begin
        dx_in[k] = quo_b[k] - pixel_x;
      end
      if (pixel_y >= quo_b[NUM_SOURCES + k][7:0]) begin
        dy_in[k] = pixel_y - quo_b[NUM_SOURCES + k][7:0];
      end else begin
        dy_in[k] = quo_b[NUM_SOURCES + k][7:0] - pixel_y;
      end
    end
  end

  logic [7:0] s1_arg [4];
  logic [8:0] s1_dx  [NUM_SOURCES];
  logic [7:0] s1_dy  [NUM_SOURCES];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_arg <= arg_in;
      s1_dx  <= dx_in;
      s1_dy  <= dy_in;
    end
  end

  // stage 2: select the triangle arguments of the active mode
  logic [7:0] dist8  [NUM_SOURCES];
  logic [7:0] arg_s2 [4];

  always_comb begin
    for (int k = 0; k < NUM_SOURCES; k++) begin
      dist8[k] = s1_dx[k][7:0] + s1_dy[k];
      if (pattern_sel == MODE_SOURCES) begin
        arg_s2[k] = 8'(dist8[k] * SOURCE_MUL[k]) + source_phase[k][7:0];
      end else begin
        arg_s2[k] = s1_arg[k];
      end
    end
    arg_s2[3] = s1_arg[3];
  end

  logic [7:0] s2_arg [4];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_arg <= arg_s2;
    end
  end

  // stage 3: sum of the triangle levels
  logic [9:0] sum_s3;
  logic [7:0] last_wave;

  always_comb begin
    last_wave = (pattern_sel == MODE_FOUR_WAVE) ? tri_level(s2_arg[3]) : 8'd0;
    sum_s3 = 10'(tri_level(s2_arg[0])) + 10'(tri_level(s2_arg[1]))
           + 10'(tri_level(s2_arg[2])) + 10'(last_wave);
  end

  logic [9:0] s3_sum;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum <= sum_s3;
    end
  end

  // stage 4: average, by four as a shift or by three as a reciprocal multiply
  logic [19:0] third_prod;
  logic [7:0]  level_next;

  always_comb begin
    third_prod = 20'(s3_sum) * 20'(RECIP_THREE);
    if (pattern_sel == MODE_SOURCES) begin
      level_next = third_prod[RECIP_SHIFT +: 8];
    end else begin
      level_next = s3_sum[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      level <= level_next;
    end
  end

  // no pixel is taken while phases and positions are being derived
  `WPPG_ASSERT_NOW(busy_blocks_pixels, busy, pixel_stall, "pixel item taken while busy")
  // every register write restarts the derivation
  `WPPG_ASSERT_NEXT(write_restarts_seq, cfg_write, state == SEQ_LOAD, "write did not restart")
  // a stalled level item stays put
  `WPPG_ASSERT_NEXT(level_held, level_valid && level_stall,
                    level_valid && $stable(level), "level item changed while stalled")
  // the sum of three sources never exceeds three full levels
  `WPPG_ASSERT_NOW(source_sum_bound, v3 && pattern_sel == MODE_SOURCES,
                   s3_sum <= 10'd765, "source sum out of range")

endmodule
